// ===== hdl/spimcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spimcr_pkg;

  localparam int unsigned CountBits  = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [CfgIdxBits-1:0] RegClockMode    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegPrescaleCode = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegMsbFirst     = 2'd2;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhSend = 4'b0010,
    PhRecv = 4'b0100,
    PhFin  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       cpol;
    logic       cpha;
    logic [2:0] prescale;
    logic       msb_first;
  } cfg_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi_level;
    logic       select_n;
    logic       send_taken;
    logic [7:0] recv_byte;
    logic       recv_valid;
    logic       busy_res;
    logic       done_res;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/spi_master_command_response.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SPI master with a command phase and a response phase, modes 0 to 3. Each accepted
// input transaction is one system tick and yields exactly one result transaction
// carrying the pin levels and strobes after that tick; one transaction is taken per
// clock while the output is drained, the tick logic sitting between the input ports
// and a single result register. A start latches the byte counts and drops select_n,
// command bytes are taken from send_byte when send_valid is high, then zero bytes
// are shifted and each received byte is returned with recv_valid; done_res pulses
// as select_n rises. The serial clock half period is 2^prescale_code ticks.
// Configuration writes are taken in any cycle and act from the next tick.
module spi_master_command_response (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [spimcr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [spimcr_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic                               cmd_i,
  input  wire logic [15:0]                        send_count_i,
  input  wire logic [15:0]                        recv_count_i,
  input  wire logic [7:0]                         send_byte_i,
  input  wire logic                               send_valid_i,
  input  wire logic                               miso_level_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               sclk_o,
  output      logic                               mosi_level_o,
  output      logic                               select_n_o,
  output      logic                               send_taken_o,
  output      logic [7:0]                         recv_byte_o,
  output      logic                               recv_valid_o,
  output      logic                               busy_res_o,
  output      logic                               done_res_o
);
  import spimcr_pkg::*;

  cfg_t    cfg_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    accept;
  logic    cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cpol: 1'b0, cpha: 1'b0, prescale: 3'd0, msb_first: 1'b1};
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegClockMode: begin
          cfg_q.cpol <= cfg_data_i[1];
          cfg_q.cpha <= cfg_data_i[0];
        end
        RegPrescaleCode: cfg_q.prescale  <= cfg_data_i[2:0];
        RegMsbFirst:     cfg_q.msb_first <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  spimcr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd_i),
    .send_count_i (send_count_i),
    .recv_count_i (recv_count_i),
    .send_byte_i  (send_byte_i),
    .send_valid_i (send_valid_i),
    .miso_level_i (miso_level_i),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sclk_o       = res_q.sclk;
  assign mosi_level_o = res_q.mosi_level;
  assign select_n_o   = res_q.select_n;
  assign send_taken_o = res_q.send_taken;
  assign recv_byte_o  = res_q.recv_byte;
  assign recv_valid_o = res_q.recv_valid;
  assign busy_res_o   = res_q.busy_res;
  assign done_res_o   = res_q.done_res;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.select_n == !res_q.busy_res))
    else $error("select and busy disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done_res) |-> (res_q.select_n && !res_q.mosi_level))
    else $error("done without released select");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.recv_valid) |-> (res_q.recv_byte == 8'd0))
    else $error("stray receive byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.send_taken || res_q.recv_valid)) |-> res_q.busy_res)
    else $error("data strobe while idle");

endmodule
`default_nettype wire

// ===== hdl/spimcr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spimcr_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire spimcr_pkg::cfg_t   cfg_i,
  input  wire logic               cmd_i,
  input  wire logic [15:0]        send_count_i,
  input  wire logic [15:0]        recv_count_i,
  input  wire logic [7:0]         send_byte_i,
  input  wire logic               send_valid_i,
  input  wire logic               miso_level_i,
  output spimcr_pkg::result_t     res_o
);
  import spimcr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [6:0] div_q, div_d;
  logic [3:0] edge_q, edge_d;
  logic [7:0] so_q, so_d;
  logic [7:0] si_q, si_d;
  count_t     sl_q, sl_d;
  count_t     rl_q, rl_d;
  logic       clk_q, clk_d;
  logic       loaded_q, loaded_d;

  logic [6:0] limit;
  logic [4:0] edge_inc;
  logic       sample;
  logic [3:0] edge_m1;
  logic [2:0] bit_idx;

  assign limit = 7'h7f >> (3'd7 - cfg_i.prescale);

  always_comb begin
    phase_d  = phase_q;
    div_d    = div_q;
    edge_d   = edge_q;
    so_d     = so_q;
    si_d     = si_q;
    sl_d     = sl_q;
    rl_d     = rl_q;
    clk_d    = clk_q;
    loaded_d = loaded_q;
    edge_inc = {1'b0, edge_q} + 5'd1;
    sample   = cfg_i.cpha ? edge_q[0] : ~edge_q[0];

    res_o.send_taken = 1'b0;
    res_o.recv_valid = 1'b0;
    res_o.recv_byte  = 8'd0;
    res_o.done_res   = 1'b0;

    case (phase_q)
      PhIdle: begin
        clk_d = cfg_i.cpol;
        if (cmd_i) begin
          sl_d     = send_count_i[CountBits-1:0];
          rl_d     = recv_count_i[CountBits-1:0];
          div_d    = 7'd0;
          edge_d   = 4'd0;
          loaded_d = 1'b0;
          if (send_count_i[CountBits-1:0] != '0) begin
            phase_d = PhSend;
          end else if (recv_count_i[CountBits-1:0] != '0) begin
            phase_d = PhRecv;
          end else begin
            phase_d = PhFin;
          end
        end
      end
      PhFin: begin
        phase_d        = PhIdle;
        loaded_d       = 1'b0;
        clk_d          = cfg_i.cpol;
        res_o.done_res = 1'b1;
      end
      PhSend, PhRecv: begin
        if (!loaded_q) begin
          if (phase_q == PhSend) begin
            if (send_valid_i) begin
              so_d             = send_byte_i;
              res_o.send_taken = 1'b1;
              loaded_d         = 1'b1;
            end
          end else begin
            so_d     = 8'd0;
            loaded_d = 1'b1;
          end
          if (loaded_d) begin
            si_d   = 8'd0;
            div_d  = 7'd0;
            edge_d = 4'd0;
          end
        end else if (div_q >= limit) begin
          div_d = 7'd0;
          clk_d = ~clk_q;
          if (sample) begin
            si_d = cfg_i.msb_first ? {si_q[6:0], miso_level_i}
                                   : {miso_level_i, si_q[7:1]};
          end
          edge_d = edge_inc[3:0];
          if (edge_inc[4]) begin
            loaded_d = 1'b0;
            if (phase_q == PhSend) begin
              sl_d = sl_q - count_t'(1);
              if (sl_d == '0) begin
                phase_d = (rl_q != '0) ? PhRecv : PhFin;
              end
            end else begin
              res_o.recv_valid = 1'b1;
              res_o.recv_byte  = si_d;
              rl_d = rl_q - count_t'(1);
              if (rl_d == '0) begin
                phase_d = PhFin;
              end
            end
          end
        end else begin
          div_d = div_q + 7'd1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    edge_m1 = edge_d - 4'd1;
    if (cfg_i.cpha) begin
      bit_idx = (edge_d == 4'd0) ? 3'd0 : edge_m1[3:1];
    end else begin
      bit_idx = edge_d[3:1];
    end
    if (cfg_i.msb_first) begin
      bit_idx = ~bit_idx;
    end

    res_o.sclk       = clk_d;
    res_o.mosi_level = loaded_d & so_d[bit_idx];
    res_o.select_n   = (phase_d == PhIdle);
    res_o.busy_res   = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      div_q    <= 7'd0;
      edge_q   <= 4'd0;
      so_q     <= 8'd0;
      si_q     <= 8'd0;
      sl_q     <= '0;
      rl_q     <= '0;
      clk_q    <= 1'b0;
      loaded_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      div_q    <= div_d;
      edge_q   <= edge_d;
      so_q     <= so_d;
      si_q     <= si_d;
      sl_q     <= sl_d;
      rl_q     <= rl_d;
      clk_q    <= clk_d;
      loaded_q <= loaded_d;
    end
  end

  // bytes only shift in the data phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> (phase_q == PhSend || phase_q == PhRecv))
    else $error("byte loaded outside data phase");

  // no edge may advance past the sixteenth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && loaded_q && div_q >= limit && edge_q == 4'd15) |=> !loaded_q)
    else $error("byte not released after last edge");

  // a counter reaching zero leaves its phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRecv) |-> (rl_q != '0))
    else $error("receive phase with nothing left");

endmodule
`default_nettype wire
